// ===== sv/rdiv_pkg.sv =====
// Package with shared types and constants of the pipelined restoring divider.
package rdiv_pkg;

   localparam int ROUNDS_PER_STAGE = 2;

   typedef struct packed {
      logic valid;
   } stage_ctl_type;

endpackage

// ===== sv/rdiv_stage.sv =====
// One pipeline stage of the restoring divider that runs ROUNDS division rounds.
module rdiv_stage #(
   parameter int WIDTH  = 24,
   parameter int ROUNDS = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  rdiv_pkg::stage_ctl_type ctl_i,
   input  logic [WIDTH-1:0]       nq_i,
   input  logic [WIDTH-1:0]       rem_i,
   input  logic [WIDTH-1:0]       den_i,
   output rdiv_pkg::stage_ctl_type ctl_o,
   output logic [WIDTH-1:0]       nq_o,
   output logic [WIDTH-1:0]       rem_o,
   output logic [WIDTH-1:0]       den_o
);
   import rdiv_pkg::*;

   stage_ctl_type    ctl_ff;
   logic [WIDTH-1:0] nq_ff;
   logic [WIDTH-1:0] rem_ff;
   logic [WIDTH-1:0] den_ff;
   logic [WIDTH-1:0] nq_in;
   logic [WIDTH-1:0] rem_in;

   // The nq register holds the unused dividend bits at its top, while quotient bits fill in from below.
   always_comb begin
      logic [WIDTH-1:0] nq_v;
      logic [WIDTH-1:0] rem_v;
      logic [WIDTH:0]   trial;
      nq_v  = nq_i;
      rem_v = rem_i;
      for (int r = 0; r < ROUNDS; r++) begin
         trial = {rem_v, nq_v[WIDTH-1]} - {1'b0, den_i};
         if (!trial[WIDTH]) begin
            rem_v = trial[WIDTH-1:0];
            nq_v  = {nq_v[WIDTH-2:0], 1'b1};
         end else begin
            rem_v = {rem_v[WIDTH-2:0], nq_v[WIDTH-1]};
            nq_v  = {nq_v[WIDTH-2:0], 1'b0};
         end
      end
      nq_in  = nq_v;
      rem_in = rem_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff.valid <= ctl_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         nq_ff  <= nq_in;
         rem_ff <= rem_in;
         den_ff <= den_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign nq_o  = nq_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;

endmodule

// ===== sv/restoring_divider_24bit_top.sv =====
// Top level of the pipelined unsigned restoring divider.
// Throughput: one division per cycle unless the result is stalled; each pipeline stage runs up to two restoring rounds.
// A stalled result freezes the whole pipeline, so nothing is lost or repeated.
// Reset (synchronous, active high) clears all stage valid bits; data registers are not reset.
module restoring_divider_24bit_top #(
   parameter int DATA_WIDTH = 24
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0 up: dividend, divisor, zero padding.
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0 up: quotient, remainder, zero padding.
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata
);
   import rdiv_pkg::*;

   localparam int NUM_STAGES = (DATA_WIDTH + ROUNDS_PER_STAGE - 1) / ROUNDS_PER_STAGE;
   localparam int BUS_WIDTH  = ((2*DATA_WIDTH+7)/8)*8;

   logic                  enable;
   stage_ctl_type         ctl_w [NUM_STAGES+1];
   logic [DATA_WIDTH-1:0] nq_w  [NUM_STAGES+1];
   logic [DATA_WIDTH-1:0] rem_w [NUM_STAGES+1];
   logic [DATA_WIDTH-1:0] den_w [NUM_STAGES+1];

   assign enable     = !ctl_w[NUM_STAGES].valid || rsp_tready;
   assign req_tready = enable;

   assign ctl_w[0].valid = req_tvalid;
   assign nq_w[0]        = req_tdata[DATA_WIDTH-1:0];
   assign rem_w[0]       = '0;
   assign den_w[0]       = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      localparam int LEFT   = DATA_WIDTH - s * ROUNDS_PER_STAGE;
      localparam int ROUNDS = (LEFT < ROUNDS_PER_STAGE) ? LEFT : ROUNDS_PER_STAGE;
      rdiv_stage #(
         .WIDTH  (DATA_WIDTH),
         .ROUNDS (ROUNDS)
      ) u_stage (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .ctl_i  (ctl_w[s]),
         .nq_i   (nq_w[s]),
         .rem_i  (rem_w[s]),
         .den_i  (den_w[s]),
         .ctl_o  (ctl_w[s+1]),
         .nq_o   (nq_w[s+1]),
         .rem_o  (rem_w[s+1]),
         .den_o  (den_w[s+1])
      );
   end

   assign rsp_tvalid = ctl_w[NUM_STAGES].valid;
   assign rsp_tdata  = BUS_WIDTH'({rem_w[NUM_STAGES], nq_w[NUM_STAGES]});

   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("Input accepted while the result is stalled.");

   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && den_w[NUM_STAGES] != '0 |-> rem_w[NUM_STAGES] < den_w[NUM_STAGES])
      else $error("Remainder is not below the divisor.");

   a_zero_den_quotient : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && den_w[NUM_STAGES] == '0 |-> &nq_w[NUM_STAGES])
      else $error("Zero divisor did not give an all-ones quotient.");

endmodule

// ===== tb/division_checker.sv =====
// Watches both streams of the divider, predicts each quotient and remainder, and counts mismatches.
module division_checker #(
   parameter int DATA_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // Fields from bit 0 up: dividend, divisor, zero padding.
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // Fields from bit 0 up: quotient, remainder, zero padding.
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   output int                                   mismatch_count,
   output int                                   outstanding,
   output int                                   results_checked
);

   localparam int W = DATA_WIDTH;

   typedef struct packed {
      logic [W-1:0] remainder;
      logic [W-1:0] quotient;
   } quotient_pair_type;

   quotient_pair_type expected_results[$];

   function automatic quotient_pair_type divide_restoring(input logic [W-1:0] num,
                                                          input logic [W-1:0] den);
      quotient_pair_type res;
      logic [W-1:0]      quo;
      logic [W-1:0]      rem;
      logic              carry;
      quo = '0;
      rem = '0;
      for (int r = W - 1; r >= 0; r--) begin
         carry = rem[W-1];
         rem = {rem[W-2:0], num[r]};
         quo = {quo[W-2:0], 1'b0};
         // A bit shifted out of the top means the trial subtraction cannot borrow.
         if (carry || rem >= den) begin
            rem = rem - den;
            quo[0] = 1'b1;
         end
      end
      res.quotient = quo;
      res.remainder = rem;
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) begin
         $display("MISMATCH at %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      quotient_pair_type got;
      quotient_pair_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[2*W-1:0];
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result transfer q=%h r=%h with no division pending",
                                         got.quotient, got.remainder));
            end else begin
               want = expected_results.pop_front();
               if (got.quotient !== want.quotient) begin
                  report_mismatch($sformatf("quotient %h, expected %h",
                                            got.quotient, want.quotient));
               end
               if (got.remainder !== want.remainder) begin
                  report_mismatch($sformatf("remainder %h, expected %h",
                                            got.remainder, want.remainder));
               end
            end
            results_checked <= results_checked + 1;
         end
         if (req_tvalid && req_tready) begin
            expected_results.push_back(divide_restoring(req_tdata[W-1:0], req_tdata[2*W-1:W]));
         end
      end
      outstanding <= expected_results.size();
   end

endmodule

// ===== tb/restoring_divider_24bit_top_tb.sv =====
// Testbench top for the restoring divider: clock, reset, stimulus, stall control and verdict.
module restoring_divider_24bit_top_tb;

   localparam int W      = 24;
   localparam int TDW    = ((2*W+7)/8)*8;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_ITEMS = 270;

   logic           clock;
   logic           reset;
   logic           req_tvalid;
   logic           req_tready;
   logic [TDW-1:0] req_tdata;
   logic           rsp_tvalid;
   logic           rsp_tready;
   logic [TDW-1:0] rsp_tdata;

   int mismatch_count;
   int outstanding;
   int results_checked;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_seq = 0;
   int items_sent = 0;
   int zero_divisors = 0;
   int top_bit_divisors = 0;

   restoring_divider_24bit_top #(.DATA_WIDTH(W)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   division_checker #(.DATA_WIDTH(W)) div_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .mismatch_count  (mismatch_count),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

   // The receiver runs its own long hold-off whenever the stimulus bumps hold_seq.
   initial begin : receiver
      int hold_seen;
      hold_seen = 0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_division(input logic [W-1:0] dividend, input logic [W-1:0] divisor);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= TDW'({$urandom, $urandom});
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {divisor, dividend};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (divisor == '0) zero_divisors++;
      if (divisor[W-1]) top_bit_divisors++;
   endtask

   task automatic wait_for_drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [W-1:0] a;
      logic [W-1:0] b;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_division(24'h000000, 24'h000000);
      send_division(24'hFFFFFF, 24'h000000);
      send_division(24'h123456, 24'h000000);
      send_division(24'h000000, 24'h000001);
      send_division(24'hFFFFFF, 24'h000001);
      send_division(24'hFFFFFF, 24'hFFFFFF);
      send_division(24'hFFFFFE, 24'hFFFFFF);
      send_division(24'hFFFFFF, 24'hFFFFFE);
      send_division(24'h800000, 24'h800000);
      send_division(24'hFFFFFF, 24'h800000);
      send_division(24'h7FFFFF, 24'h800000);
      send_division(24'hFFFFFF, 24'hC00000);
      send_division(24'hFFFFFF, 24'h800001);
      send_division(24'hC00000, 24'hC00001);
      send_division(24'hFFFFFF, 24'h000002);
      send_division(24'hFFFFFF, 24'h000003);
      send_division(24'h000001, 24'hFFFFFF);
      send_division(24'h000001, 24'h000001);
      send_division(24'hAAAAAA, 24'h555555);
      send_division(24'h555555, 24'hAAAAAA);
      send_division(24'h123456, 24'h000100);
      send_division(24'h000000, 24'hFFFFFF);
      wait_for_drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 81;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 81;
            end
            default: begin
               send_idle_pct = 32;
               stall_pct <= 32;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase == 0 && i == 100) begin
               hold_seq <= hold_seq + 1;
            end
            a = W'($urandom);
            b = W'($urandom);
            case ($urandom_range(19))
               0: b = '0;
               1, 2: b[W-1] = 1'b1;
               3, 4, 5: b = W'($urandom_range(255, 1));
               6, 7: begin
                  b = b | 24'h1;
                  a = a % b;
               end
               8: b = 24'h1 << $urandom_range(W - 1);
               9: begin
                  b = W'($urandom_range(4095, 1));
                  a = W'(b * $urandom_range(4095) + $urandom_range(7));
               end
               10: a = W'(24'hFFFFFF - $urandom_range(255));
               default: ;
            endcase
            send_division(a, b);
         end
         wait_for_drain();
      end

      repeat (40) @(posedge clock);
      $display("Summary: %0d divisions sent, %0d results checked, %0d zero divisors,",
               items_sent, results_checked, zero_divisors);
      $display("%0d divisors with top bit set; idle mixes: none, sender 81%%, receiver 81%%,",
               top_bit_divisors);
      $display("both 32%%, plus one %0d-cycle result stall.", LONG_HOLD);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== restoring_divider_24bit_top.f =====
sv/rdiv_pkg.sv
sv/rdiv_stage.sv
sv/restoring_divider_24bit_top.sv
tb/division_checker.sv
tb/restoring_divider_24bit_top_tb.sv
